// File: rtl/dobs_pkg.sv
// ----------------------------------------------------------------------------
// dobs_pkg
// Shared types, constants and state codes for the open-row bank scheduler.
// ----------------------------------------------------------------------------
package dobs_pkg;

    localparam int BANKS_DEF           = 8;
    localparam int MAX_OUTSTANDING_DEF = 16;
    localparam int ID_W                = 16;
    localparam int ROW_W               = 16;
    localparam int BANK_FIELD_W        = 3;
    localparam int LAT_W               = 10;
    localparam int CNT_W               = 32;
    localparam int CFG_IDX_W           = 1;
    localparam int CFG_DATA_W          = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_HIT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_MISS = 1'd1;

    localparam logic [9:0] HIT_LAT_RST  = 10'd4;
    localparam logic [9:0] MISS_LAT_RST = 10'd12;

    typedef struct packed {
        logic [ID_W-1:0]         id;
        logic [BANK_FIELD_W-1:0] bank;
        logic [ROW_W-1:0]        row;
    } req_t;

    typedef struct packed {
        logic            accepted;
        logic            done_valid;
        logic [ID_W-1:0] done_id;
        logic [CNT_W-1:0] row_hits;
        logic [CNT_W-1:0] row_misses;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_DRAIN,
        ST_SCHED_RD,
        ST_SCHED,
        ST_MOVE,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic do_req;
        logic do_pop;
        logic do_drain;
        logic do_sched_rd;
        logic do_sched;
        logic do_move;
        logic bank_clr;
        logic bank_inc;
        logic rsp_load;
    } cmd_t;

    typedef struct packed {
        logic last_bank;
        logic rsp_taken;
    } sts_t;

endpackage

// File: rtl/dobs_if.sv
// ----------------------------------------------------------------------------
// dobs_if
// Valid/ready channel carrying one payload of parametric type.
// ----------------------------------------------------------------------------
interface dobs_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dobs_ram.sv
// ----------------------------------------------------------------------------
// dobs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dobs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/dobs_ctrl.sv
// ----------------------------------------------------------------------------
// dobs_ctrl
// Sequencer: steps a tick through pop, per-bank drain and schedule, queue move.
// ----------------------------------------------------------------------------
module dobs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_type,
    output logic            in_ready,
    input  dobs_pkg::sts_t  sts,
    output dobs_pkg::cmd_t  cmd
);
    import dobs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_type ? ST_RESP : ST_POP;
                end
            end
            ST_POP:      state_next = ST_DRAIN;
            ST_DRAIN:    state_next = sts.last_bank ? ST_SCHED_RD : ST_DRAIN;
            ST_SCHED_RD: state_next = ST_SCHED;
            ST_SCHED:    state_next = sts.last_bank ? ST_MOVE : ST_SCHED_RD;
            ST_MOVE:     state_next = ST_RESP;
            ST_RESP:     state_next = sts.rsp_taken ? ST_IDLE : ST_RESP;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.bank_clr = 1'b1;
                cmd.do_req   = in_valid & in_type;
            end
            ST_POP:      cmd.do_pop = 1'b1;
            ST_DRAIN:
            begin
                cmd.do_drain = 1'b1;
                cmd.bank_inc = 1'b1;
            end
            ST_SCHED_RD: cmd.do_sched_rd = 1'b1;
            ST_SCHED:
            begin
                cmd.do_sched = 1'b1;
                cmd.bank_inc = 1'b1;
            end
            ST_MOVE:
            begin
                cmd.do_move  = 1'b1;
                cmd.rsp_load = 1'b1;
            end
            ST_RESP:     ;
            default:     ;
        endcase
    end
endmodule

// File: rtl/dobs_dp.sv
// ----------------------------------------------------------------------------
// dobs_dp
// Datapath: queues, bank table, counters and result register.
// ----------------------------------------------------------------------------
module dobs_dp #(
    parameter int BANKS           = dobs_pkg::BANKS_DEF,
    parameter int MAX_OUTSTANDING = dobs_pkg::MAX_OUTSTANDING_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dobs_pkg::cmd_t       cmd,
    output dobs_pkg::sts_t       sts,
    input  dobs_pkg::req_t       req,
    input  logic                 in_accept,
    input  logic                 cfg_we,
    input  logic [dobs_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [dobs_pkg::CFG_DATA_W-1:0] cfg_data,
    output dobs_pkg::rsp_t       rsp,
    output logic                 rsp_valid,
    input  logic                 rsp_ready
);
    import dobs_pkg::*;

    localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int QW  = (MAX_OUTSTANDING > 1) ? $clog2(MAX_OUTSTANDING) : 1;
    localparam int CW  = $clog2(MAX_OUTSTANDING + 1);
    localparam int EW  = ID_W + ROW_W + 1;
    localparam int RD  = BANKS * MAX_OUTSTANDING;
    localparam int RAW = BW + QW;

    logic [LAT_W-1:0] hit_lat_reg, miss_lat_reg;
    logic [CNT_W-1:0] cycle_reg, hits_reg, misses_reg;
    logic [CW-1:0]    outst_reg;

    // new-request FIFO and in queue (both plain FIFOs), out queue of ids
    req_t          nf_mem [MAX_OUTSTANDING];
    logic [QW-1:0] nf_head_reg;
    logic [CW-1:0] nf_cnt_reg;
    req_t          iq_mem [MAX_OUTSTANDING];
    logic [QW-1:0] iq_head_reg;
    logic [CW-1:0] iq_cnt_reg;
    logic [ID_W-1:0] oq_mem [MAX_OUTSTANDING];
    logic [QW-1:0] oq_head_reg;
    logic [CW-1:0] oq_cnt_reg;

    logic [ROW_W-1:0] open_row_reg [BANKS];
    logic [BANKS-1:0] open_vld_reg;
    logic [CNT_W-1:0] ready_reg [BANKS];
    logic [QW-1:0]    bq_head_reg [BANKS];
    logic [CW-1:0]    bq_cnt_reg [BANKS];
    logic [CW-1:0]    bq_sc_reg [BANKS];

    logic [BW-1:0] bank_reg;
    rsp_t          rsp_reg;
    logic          rsp_valid_reg;
    logic          pop_v_reg;
    logic [ID_W-1:0] pop_id_reg;

    // h + k wrapped at the queue depth; both operands stay below 2 * depth
    function automatic logic [QW-1:0] qidx(input logic [QW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(k);
        if (s >= (CW+1)'(MAX_OUTSTANDING))
        begin
            s = s - (CW+1)'(MAX_OUTSTANDING);
        end
        return s[QW-1:0];
    endfunction

    // bank field folded into the bank range by repeated subtraction
    function automatic logic [BW-1:0] bank_sel(input logic [BANK_FIELD_W-1:0] b);
        int v;
        v = int'(b);
        for (int i = 0; i < (1 << BANK_FIELD_W); i++)
        begin
            if (v >= BANKS)
            begin
                v = v - BANKS;
            end
        end
        return BW'(v);
    endfunction

    // bank queue RAM: entry = id, row (sched kept as a per-bank count)
    logic           ram_we;
    logic [RAW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0]  ram_wdata, ram_rdata;

    dobs_ram #(.WIDTH(EW), .DEPTH(1 << RAW)) u_bq_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic [BW-1:0] mv_bank;
    req_t          iq_head;
    logic          mv_ok;
    logic          bank_idle;
    logic [CW-1:0] cur_cnt, cur_sc;
    logic          last;

    assign iq_head   = iq_mem[iq_head_reg];
    assign mv_bank   = bank_sel(iq_head.bank);
    assign mv_ok     = cmd.do_move && (iq_cnt_reg != '0)
                       && (bq_cnt_reg[mv_bank] < CW'(MAX_OUTSTANDING));
    assign cur_cnt   = bq_cnt_reg[bank_reg];
    assign cur_sc    = bq_sc_reg[bank_reg];
    assign bank_idle = ready_reg[bank_reg] < cycle_reg;
    assign last      = (bank_reg == BW'(BANKS - 1));

    always_comb
    begin
        ram_we    = mv_ok;
        ram_waddr = {mv_bank, qidx(bq_head_reg[mv_bank], bq_cnt_reg[mv_bank])};
        ram_wdata = {iq_head.id, iq_head.row, 1'b0};
        if (cmd.do_drain)
        begin
            ram_raddr = {bank_reg, bq_head_reg[bank_reg]};
        end
        else
        begin
            ram_raddr = {bank_reg, qidx(bq_head_reg[bank_reg], cur_sc)};
        end
    end

    assign sts.last_bank = last;
    assign sts.rsp_taken = rsp_valid_reg & rsp_ready;
    assign rsp           = rsp_reg;
    assign rsp_valid     = rsp_valid_reg;

    // drain reads the head id over the RAM; a pending drain id lands next cycle
    logic            dr_pend_reg;
    logic            drain_hit;

    assign drain_hit = cmd.do_drain && (cur_sc != '0) && bank_idle;

    logic            hit;
    assign hit = open_vld_reg[bank_reg]
                 && (open_row_reg[bank_reg] == ram_rdata[ROW_W:1]);

    logic oq_push;
    logic [CW-1:0] oq_cnt_pop;
    assign oq_push = dr_pend_reg && (oq_cnt_reg < CW'(MAX_OUTSTANDING));

    always_ff @(posedge clk)
    begin
        if (in_accept && cmd.do_req && (outst_reg < CW'(MAX_OUTSTANDING))
            && (nf_cnt_reg < CW'(MAX_OUTSTANDING)))
        begin
            nf_mem[qidx(nf_head_reg, nf_cnt_reg)] <= req;
        end
        if (cmd.do_move && (nf_cnt_reg != '0)
            && (iq_cnt_reg - CW'(iq_cnt_reg != '0) < CW'(MAX_OUTSTANDING)))
        begin
            iq_mem[qidx(iq_head_reg, iq_cnt_reg)] <= nf_mem[nf_head_reg];
        end
        if (oq_push)
        begin
            oq_mem[qidx(oq_head_reg, oq_cnt_reg)] <= ram_rdata[EW-1 -: ID_W];
        end
        if (cmd.do_sched_rd && (cur_cnt > cur_sc) && bank_idle)
        begin
            ;
        end
        if (cmd.do_sched && (cur_cnt > cur_sc) && bank_idle)
        begin
            open_row_reg[bank_reg] <= ram_rdata[ROW_W:1];
        end
        if (cmd.do_pop)
        begin
            pop_id_reg <= oq_mem[oq_head_reg];
        end
        if (cmd.rsp_load)
        begin
            rsp_reg.accepted   <= 1'b0;
            rsp_reg.done_valid <= pop_v_reg;
            rsp_reg.done_id    <= pop_v_reg ? pop_id_reg : '0;
            rsp_reg.row_hits   <= hits_reg;
            rsp_reg.row_misses <= misses_reg;
        end
        else if (in_accept && cmd.do_req)
        begin
            rsp_reg.accepted   <= (outst_reg < CW'(MAX_OUTSTANDING));
            rsp_reg.done_valid <= 1'b0;
            rsp_reg.done_id    <= '0;
            rsp_reg.row_hits   <= hits_reg;
            rsp_reg.row_misses <= misses_reg;
        end
    end

    assign oq_cnt_pop = oq_cnt_reg - CW'(cmd.do_pop && (oq_cnt_reg != '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_lat_reg   <= HIT_LAT_RST;
            miss_lat_reg  <= MISS_LAT_RST;
            cycle_reg     <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            outst_reg     <= '0;
            nf_head_reg   <= '0;
            nf_cnt_reg    <= '0;
            iq_head_reg   <= '0;
            iq_cnt_reg    <= '0;
            oq_head_reg   <= '0;
            oq_cnt_reg    <= '0;
            open_vld_reg  <= '0;
            bank_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            pop_v_reg     <= 1'b0;
            dr_pend_reg   <= 1'b0;
            for (int b = 0; b < BANKS; b++)
            begin
                ready_reg[b]   <= '0;
                bq_head_reg[b] <= '0;
                bq_cnt_reg[b]  <= '0;
                bq_sc_reg[b]   <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_ROW_HIT:  hit_lat_reg  <= cfg_data[LAT_W-1:0];
                    CFG_ROW_MISS: miss_lat_reg <= cfg_data[LAT_W-1:0];
                    default:      ;
                endcase
            end
            if (in_accept && cmd.do_req)
            begin
                rsp_valid_reg <= 1'b1;
                if (outst_reg < CW'(MAX_OUTSTANDING))
                begin
                    outst_reg <= outst_reg + 1'b1;
                    if (nf_cnt_reg < CW'(MAX_OUTSTANDING))
                    begin
                        nf_cnt_reg <= nf_cnt_reg + 1'b1;
                    end
                end
            end
            if (cmd.rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            if (sts.rsp_taken)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (cmd.bank_clr)
            begin
                bank_reg <= '0;
            end
            else if (cmd.bank_inc)
            begin
                bank_reg <= last ? '0 : bank_reg + 1'b1;
            end

            // step 1
            if (cmd.do_pop)
            begin
                pop_v_reg <= (oq_cnt_reg != '0);
                if (oq_cnt_reg != '0)
                begin
                    oq_head_reg <= qidx(oq_head_reg, CW'(1));
                    if (outst_reg != '0)
                    begin
                        outst_reg <= outst_reg - 1'b1;
                    end
                end
            end

            // step 2: read head id this cycle, push it to the out queue next cycle
            dr_pend_reg <= drain_hit;
            if (drain_hit)
            begin
                bq_head_reg[bank_reg] <= qidx(bq_head_reg[bank_reg], CW'(1));
                bq_cnt_reg[bank_reg]  <= cur_cnt - 1'b1;
                bq_sc_reg[bank_reg]   <= cur_sc - 1'b1;
            end
            oq_cnt_reg <= oq_cnt_pop + CW'(oq_push);

            // step 3
            if (cmd.do_sched && (cur_cnt > cur_sc) && bank_idle)
            begin
                if (hit)
                begin
                    hits_reg <= hits_reg + 1'b1;
                    ready_reg[bank_reg] <= cycle_reg + CNT_W'(hit_lat_reg);
                end
                else
                begin
                    misses_reg <= misses_reg + 1'b1;
                    ready_reg[bank_reg] <= cycle_reg + CNT_W'(miss_lat_reg);
                end
                open_vld_reg[bank_reg] <= 1'b1;
                bq_sc_reg[bank_reg]    <= cur_sc + 1'b1;
            end

            // steps 4 and 5
            if (cmd.do_move)
            begin
                if (iq_cnt_reg != '0)
                begin
                    iq_head_reg <= qidx(iq_head_reg, CW'(1));
                    if (mv_ok)
                    begin
                        bq_cnt_reg[mv_bank] <= bq_cnt_reg[mv_bank] + 1'b1;
                    end
                end
                iq_cnt_reg <= iq_cnt_reg - CW'(iq_cnt_reg != '0)
                              + CW'((nf_cnt_reg != '0)
                                    && (iq_cnt_reg - CW'(iq_cnt_reg != '0)
                                        < CW'(MAX_OUTSTANDING)));
                if (nf_cnt_reg != '0)
                begin
                    nf_head_reg <= qidx(nf_head_reg, CW'(1));
                    nf_cnt_reg  <= nf_cnt_reg - 1'b1;
                end
                cycle_reg <= cycle_reg + 1'b1;
            end
        end
    end
endmodule

// File: rtl/dram_open_row_bank_scheduler_core.sv
// ----------------------------------------------------------------------------
// dram_open_row_bank_scheduler_core
// Open-row DRAM bank scheduler, first-come first-served within each bank.
// ----------------------------------------------------------------------------
// One item is handled at a time. A request item's result is valid the cycle
// after acceptance. A tick item's result becomes valid after the completion
// pop, a drain pass over every bank, a scheduling pass that reads the bank
// queue RAM and then decides for each bank, and the queue moves. The passes
// go bank by bank because the bank queue RAM is shared by all banks.
// The next item is accepted from the cycle after the result transfer.
module dram_open_row_bank_scheduler_core #(
    parameter int BANKS           = dobs_pkg::BANKS_DEF,
    parameter int MAX_OUTSTANDING = dobs_pkg::MAX_OUTSTANDING_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    dobs_if.sink                                req_ch,
    dobs_if.source                              rsp_ch,
    input  logic                                cfg_we,
    input  logic [dobs_pkg::CFG_IDX_W-1:0]      cfg_idx,
    input  logic [dobs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dobs_pkg::*;

    cmd_t  cmd;
    sts_t  sts;
    logic  in_ready;
    req_t  req;
    rsp_t  rsp;

    typedef struct packed {
        logic             req_type;
        logic [ID_W-1:0]  req_id;
        logic [2:0]       req_bank;
        logic [ROW_W-1:0] req_row;
    } in_t;

    in_t in_d;
    assign in_d         = req_ch.data;
    assign req.id       = in_d.req_id;
    assign req.bank     = in_d.req_bank;
    assign req.row      = in_d.req_row;
    assign req_ch.ready = in_ready;
    assign rsp_ch.data  = rsp;

    dobs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req_ch.valid),
        .in_type  (in_d.req_type),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dobs_dp #(.BANKS(BANKS), .MAX_OUTSTANDING(MAX_OUTSTANDING)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .in_accept (req_ch.valid & in_ready),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data),
        .rsp       (rsp),
        .rsp_valid (rsp_ch.valid),
        .rsp_ready (rsp_ch.ready)
    );
endmodule
